@@ src/ifp_pkg.sv @@
// ----------------------------------------------------------------------------
// ifp_pkg: shared types and constants of the improv frame parser
// Header characters, frame positions, result codes and the payload store size.
// ----------------------------------------------------------------------------
package ifp_pkg;

   localparam int PAYLOAD_DEPTH = 256;
   localparam int PAYLOAD_AW    = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;

   localparam int POS_W = 9;

   localparam logic [POS_W-1:0] HDR_LEN       = 9'd6;
   localparam logic [POS_W-1:0] POS_VERSION   = 9'd6;
   localparam logic [POS_W-1:0] POS_TYPE      = 9'd7;
   localparam logic [POS_W-1:0] BODY_START    = 9'd9;
   localparam logic [POS_W-1:0] PAYLOAD_LIMIT = POS_W'(PAYLOAD_DEPTH);

   localparam logic [7:0] GOOD_VERSION = 8'h01;
   localparam logic [7:0] HDR_FIRST    = "I";

   typedef enum logic {
      CMD_FEED = 1'b0,
      CMD_READ = 1'b1
   } cmd_type;

   typedef enum logic {
      KIND_REPORT = 1'b0,
      KIND_READ   = 1'b1
   } kind_type;

   typedef enum logic [1:0] {
      FRAME_OK      = 2'd0,
      FRAME_BAD_SUM = 2'd1,
      FRAME_BAD_VER = 2'd2
   } status_type;

   // one accepted input transaction
   typedef struct packed {
      logic       cmd;
      logic [7:0] in_byte;
      logic [7:0] read_index;
   } item_type;

   // what the parser makes of the item held in the input register
   typedef struct packed {
      logic       has_result;
      kind_type   kind;
      status_type status;
      logic [7:0] frame_type;
      logic [7:0] length;
      logic       in_range;
   } step_type;

   typedef struct packed {
      logic                  wr_en;
      logic [PAYLOAD_AW-1:0] wr_addr;
      logic [7:0]            wr_data;
      logic                  rd_en;
      logic [PAYLOAD_AW-1:0] rd_addr;
   } store_ctl_type;

   function automatic logic [7:0] hdr_char(input logic [2:0] pos);
      logic [7:0] c;
      case (pos)
         3'd0:    c = "I";
         3'd1:    c = "M";
         3'd2:    c = "P";
         3'd3:    c = "R";
         3'd4:    c = "O";
         3'd5:    c = "V";
         default: c = 8'h00;
      endcase
      return c;
   endfunction

endpackage

@@ src/ifp_if.sv @@
// ----------------------------------------------------------------------------
// ifp_if: request and response channels of the improv frame parser
// Valid/ready channels carrying the input item and the result item.
// ----------------------------------------------------------------------------
interface ifp_req_if;
   logic       valid;
   logic       ready;
   logic       cmd;
   logic [7:0] in_byte;
   logic [7:0] read_index;

   modport source (output valid, output cmd, output in_byte, output read_index,
                   input ready);
   modport sink   (input valid, input cmd, input in_byte, input read_index,
                   output ready);
endinterface

interface ifp_rsp_if;
   logic       valid;
   logic       ready;
   logic       result_kind;
   logic [1:0] frame_status;
   logic [7:0] frame_type;
   logic [7:0] payload_length;
   logic [7:0] read_data;
   logic       index_in_range;

   modport source (output valid, output result_kind, output frame_status,
                   output frame_type, output payload_length, output read_data,
                   output index_in_range, input ready);
   modport sink   (input valid, input result_kind, input frame_status,
                   input frame_type, input payload_length, input read_data,
                   input index_in_range, output ready);
endinterface

@@ src/ifp_ram.sv @@
// ----------------------------------------------------------------------------
// ifp_ram: generic simple dual port memory
// One write port, one read port with registered read data held when idle.
// ----------------------------------------------------------------------------
module ifp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                                         clock,
   input  logic                                         wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                             wr_data,
   input  logic                                         rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                             rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/ifp_parser.sv @@
// ----------------------------------------------------------------------------
// ifp_parser: frame tracking state and per-item decode
// Rolling header match, running checksum, held header fields and the
// payload store controls for the item in the input register.
// ----------------------------------------------------------------------------
module ifp_parser
   import ifp_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  item_type      item,
   input  logic          advance,
   output step_type      step,
   output store_ctl_type store_ctl
);

   logic [POS_W-1:0] pos_ff, pos_in;
   logic [7:0]       sum_ff, sum_in;
   logic [7:0]       version_ff, version_in;
   logic [7:0]       type_ff, type_in;
   logic [7:0]       length_ff, length_in;
   logic [7:0]       last_len_ff, last_len_in;

   logic [POS_W-1:0] body_idx;
   logic [7:0]       sum_plus;
   logic [7:0]       b;

   always_comb begin
      b        = item.in_byte;
      body_idx = pos_ff - BODY_START;
      sum_plus = sum_ff + b;

      pos_in      = pos_ff;
      sum_in      = sum_ff;
      version_in  = version_ff;
      type_in     = type_ff;
      length_in   = length_ff;
      last_len_in = last_len_ff;

      step            = '0;
      step.kind       = KIND_REPORT;
      step.status     = FRAME_OK;
      store_ctl       = '0;
      store_ctl.wr_addr = body_idx[PAYLOAD_AW-1:0];
      store_ctl.wr_data = b;
      store_ctl.rd_addr = item.read_index[PAYLOAD_AW-1:0];

      if (item.cmd == CMD_READ) begin
         step.has_result = 1'b1;
         step.kind       = KIND_READ;
         step.in_range   = (item.read_index < last_len_ff)
                        && ({1'b0, item.read_index} < PAYLOAD_LIMIT);
         store_ctl.rd_en = 1'b1;
      end else if (pos_ff < HDR_LEN) begin
         // rolling header match
         if (b == hdr_char(pos_ff[2:0])) begin
            sum_in = sum_plus;
            pos_in = pos_ff + 1'b1;
         end else if (b == HDR_FIRST) begin
            sum_in = b;
            pos_in = POS_W'(1);
         end else begin
            sum_in = '0;
            pos_in = '0;
         end
      end else if (pos_ff < BODY_START) begin
         if (pos_ff == POS_VERSION) begin
            version_in = b;
         end else if (pos_ff == POS_TYPE) begin
            type_in = b;
         end else begin
            length_in = b;
         end
         sum_in = sum_plus;
         pos_in = pos_ff + 1'b1;
      end else if (body_idx < {1'b0, length_ff}) begin
         store_ctl.wr_en = (body_idx < PAYLOAD_LIMIT);
         sum_in = sum_plus;
         pos_in = pos_ff + 1'b1;
      end else begin
         // checksum byte closes the frame
         step.has_result = 1'b1;
         step.frame_type = type_ff;
         step.length     = length_ff;
         if (b != sum_ff) begin
            step.status = FRAME_BAD_SUM;
         end else if (version_ff != GOOD_VERSION) begin
            step.status = FRAME_BAD_VER;
         end else begin
            step.status = FRAME_OK;
         end
         last_len_in = length_ff;
         pos_in      = '0;
         sum_in      = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= '0;
         sum_ff      <= '0;
         version_ff  <= '0;
         type_ff     <= '0;
         length_ff   <= '0;
         last_len_ff <= '0;
      end else if (advance) begin
         pos_ff      <= pos_in;
         sum_ff      <= sum_in;
         version_ff  <= version_in;
         type_ff     <= type_in;
         length_ff   <= length_in;
         last_len_ff <= last_len_in;
      end
   end

endmodule

@@ src/improv_frame_parser_unit.sv @@
// ----------------------------------------------------------------------------
// improv_frame_parser_unit: improv serial frame parser
// The req channel carries one transaction per received serial byte (cmd 0)
// or a payload read (cmd 1); the rsp channel returns frame reports and
// read data. A fed byte in the middle of a frame gives no response.
// Each transaction passes an input register, the parser decode and a
// response register that drives the rsp channel. Throughput is one
// transaction per cycle while the receiver does not stall, since the
// parser finishes an item while it is held in the input register.
// The payload store is a 256-entry memory written by frame bytes and read
// by read transactions; its read data feeds the response register.
// Reset clears the frame position, checksum, held header fields and the
// last frame length; the payload memory is not cleared.
// When the receiver stalls, the response register holds its transaction;
// bytes that give no response keep flowing, and req ready drops only once
// the input register holds a transaction that has a response to hand over.
// ----------------------------------------------------------------------------
module improv_frame_parser_unit
   import ifp_pkg::*;
(
   input  logic  clock,
   input  logic  reset,
   ifp_req_if.sink   req_chan,
   ifp_rsp_if.source rsp_chan
);

   logic          s1_valid_ff, s1_valid_in;
   item_type      s1_item_ff, s1_item_in;
   logic          s2_valid_ff, s2_valid_in;
   step_type      s2_step_ff, s2_step_in;

   step_type      step;
   store_ctl_type store_ctl;
   logic [7:0]    rd_data;

   logic          req_fire;
   logic          s2_load_ok;
   logic          s1_done;

   ifp_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .item      (s1_item_ff),
      .advance   (s1_done),
      .step      (step),
      .store_ctl (store_ctl)
   );

   ifp_ram #(
      .WIDTH (8),
      .DEPTH (PAYLOAD_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (s1_done && store_ctl.wr_en),
      .wr_addr (store_ctl.wr_addr),
      .wr_data (store_ctl.wr_data),
      .rd_en   (s1_done && store_ctl.rd_en),
      .rd_addr (store_ctl.rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      s2_load_ok = !s2_valid_ff || rsp_chan.ready;
      s1_done    = s1_valid_ff && (!step.has_result || s2_load_ok);
      req_chan.ready = !s1_valid_ff || s1_done;
      req_fire   = req_chan.valid && req_chan.ready;

      s1_valid_in = s1_valid_ff;
      s1_item_in  = s1_item_ff;
      if (req_fire) begin
         s1_valid_in = 1'b1;
         s1_item_in  = '{cmd: req_chan.cmd, in_byte: req_chan.in_byte,
                         read_index: req_chan.read_index};
      end else if (s1_done) begin
         s1_valid_in = 1'b0;
      end

      s2_valid_in = s2_valid_ff;
      s2_step_in  = s2_step_ff;
      if (s1_done && step.has_result) begin
         s2_valid_in = 1'b1;
         s2_step_in  = step;
      end else if (rsp_chan.ready) begin
         s2_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
      s1_item_ff <= s1_item_in;
      s2_step_ff <= s2_step_in;
   end

   // memory read data is held until the next read transaction loads
   assign rsp_chan.valid          = s2_valid_ff;
   assign rsp_chan.result_kind    = s2_step_ff.kind;
   assign rsp_chan.frame_status   = s2_step_ff.status;
   assign rsp_chan.frame_type     = s2_step_ff.frame_type;
   assign rsp_chan.payload_length = s2_step_ff.length;
   assign rsp_chan.index_in_range = s2_step_ff.in_range;
   assign rsp_chan.read_data      = s2_step_ff.in_range ? rd_data : 8'h00;

endmodule
